>>> src/mtup_pkg.sv
// Shared types, constants and lookup tables of the MIDI to USB-MIDI packetizer.
package mtup_pkg;

    // MIDI status and data bytes
    localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] REALTIME_FIRST = 8'hF8;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_SYSEX_CONT  = 4'h4;
    localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

    // Configuration register indexes
    localparam logic REG_RAW_MODE = 1'b0;
    localparam logic REG_CABLE    = 1'b1;

    // Default depth of the packet queue between parser and output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [1:0] t_len;
    typedef logic [2:0][7:0] t_msg;

    // Message length in bytes, status included, for channel messages 8x..Ex
    localparam t_len CHAN_LEN [7] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3};
    // Message length for system messages F0..FF; zero marks undefined codes and F7
    localparam t_len SYS_LEN [16] = '{2'd3, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
                                      2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1};
    // Code index of a system common message by its length less one
    localparam logic [3:0] COMMON_CODE [3] = '{4'h5, 4'h2, 4'h3};

    typedef struct packed {
        logic [3:0] code_index;
        logic [3:0] cable;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic       last_of_run;
    } t_pkt;

    // Up to two packets produced by one accepted byte
    typedef struct packed {
        logic [1:0] n;
        t_pkt       p0;
        t_pkt       p1;
    } t_push;

    typedef struct packed {
        logic       raw_mode;
        logic [3:0] cable_number;
    } t_cfg;

    function automatic t_len status_len(input logic [7:0] s);
        t_len len;
        len = 2'd0;
        if (s[7]) begin
            if (s < STATUS_SYSEX) begin
                if (s[6:4] != 3'd7) begin
                    len = CHAN_LEN[s[6:4]];
                end
            end else begin
                len = SYS_LEN[s[3:0]];
            end
        end
        return len;
    endfunction

    function automatic logic [3:0] event_code(input logic [7:0] st, input logic [1:0] cnt,
                                              input t_msg mb);
        logic [1:0] idx;
        logic [3:0] code;
        idx = (cnt == 2'd0) ? 2'd0 : cnt - 2'd1;
        if (st < STATUS_SYSEX) begin
            code = st[7:4];
        end else if (st == STATUS_SYSEX) begin
            // A closing F7 in the last filled slot turns the code into 5, 6 or 7.
            code = CIN_SYSEX_CONT;
            if (cnt != 2'd0 && mb[idx] == SYSEX_END) begin
                code = CIN_SYSEX_CONT + {2'b00, cnt};
            end
        end else if (st < REALTIME_FIRST) begin
            code = COMMON_CODE[idx];
        end else begin
            code = CIN_SINGLE_BYTE;
        end
        return code;
    endfunction

endpackage

>>> src/mtup_front.sv
// Front end: parses MIDI bytes and builds the USB-MIDI packets they complete.
module mtup_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  mtup_pkg::t_cfg       i_cfg,
    output mtup_pkg::t_push      o_push
);

    logic [7:0]    r_status;
    logic [1:0]    r_cnt;
    mtup_pkg::t_msg r_msg;
    logic [7:0]    n_status;
    logic [1:0]    n_cnt;
    mtup_pkg::t_msg n_msg;
    mtup_pkg::t_push push;

    function automatic mtup_pkg::t_pkt make_pkt(input logic [3:0] code, input logic [3:0] cab,
                                                input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        mtup_pkg::t_pkt p;
        p.code_index  = code;
        p.cable       = cab;
        p.first_byte  = a;
        p.second_byte = b;
        p.third_byte  = c;
        p.last_of_run = 1'b0;
        return p;
    endfunction

    always_comb begin
        logic [7:0]      st;
        logic [1:0]      cnt;
        mtup_pkg::t_msg  mb;
        mtup_pkg::t_pkt  pk;
        mtup_pkg::t_len  len;
        st   = r_status;
        cnt  = r_cnt;
        mb   = r_msg;
        pk   = '0;
        len  = '0;
        push = '0;
        if (i_cfg.raw_mode) begin
            push.p0 = make_pkt(mtup_pkg::CIN_SINGLE_BYTE, i_cfg.cable_number, i_byte, 8'h00,
                               8'h00);
            push.n  = 2'd1;
        end else if (i_byte >= mtup_pkg::REALTIME_FIRST) begin
            // Realtime bytes leave the parser state alone; undefined ones vanish.
            if (mtup_pkg::SYS_LEN[i_byte[3:0]] != 2'd0) begin
                push.p0 = make_pkt(mtup_pkg::CIN_SINGLE_BYTE, i_cfg.cable_number, i_byte,
                                   8'h00, 8'h00);
                push.n  = 2'd1;
            end
        end else begin
            // Any status byte closes an open sysex with an appended F7.
            if (i_byte[7] && st == mtup_pkg::STATUS_SYSEX) begin
                if (cnt < 2'd3) begin
                    mb[cnt] = mtup_pkg::SYSEX_END;
                    cnt     = cnt + 2'd1;
                end
                push.p0 = make_pkt(mtup_pkg::event_code(st, cnt, mb), i_cfg.cable_number,
                                   mb[0], mb[1], mb[2]);
                push.n  = 2'd1;
                mb      = '0;
                cnt     = 2'd0;
            end
            if (i_byte[7]) begin
                st  = i_byte;
                cnt = 2'd0;
                mb  = '0;
            end
            len = mtup_pkg::status_len(st);
            if (st != 8'h00 && len != 2'd0) begin
                if (cnt < 2'd3) begin
                    mb[cnt] = i_byte;
                    cnt     = cnt + 2'd1;
                end
                if (cnt >= len) begin
                    pk = make_pkt(mtup_pkg::event_code(st, cnt, mb), i_cfg.cable_number,
                                  mb[0], mb[1], mb[2]);
                    if (push.n == 2'd0) begin
                        push.p0 = pk;
                    end else begin
                        push.p1 = pk;
                    end
                    push.n = push.n + 2'd1;
                    mb     = '0;
                    cnt    = 2'd0;
                    // Channel messages keep running status; system common clears it.
                    if (st < mtup_pkg::STATUS_SYSEX) begin
                        mb[0] = st;
                        cnt   = 2'd1;
                    end
                    if (st > mtup_pkg::STATUS_SYSEX) begin
                        st = 8'h00;
                    end
                end
            end
        end
        if (push.n == 2'd1) begin
            push.p0.last_of_run = 1'b1;
        end else if (push.n == 2'd2) begin
            push.p1.last_of_run = 1'b1;
        end
        n_status = st;
        n_cnt    = cnt;
        n_msg    = mb;
        if (!i_accept) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 8'h00;
            r_cnt    <= 2'd0;
            r_msg    <= '0;
        end else if (i_accept) begin
            r_status <= n_status;
            r_cnt    <= n_cnt;
            r_msg    <= n_msg;
        end
    end

    assign o_push = push;

`ifndef SYNTHESIS
    // Two packets only arise when a status byte closes a sysex.
    a_pair_is_sysex_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == 2'd2) |-> (o_push.p0.code_index == 4'h5 ||
                                o_push.p0.code_index == 4'h6 ||
                                o_push.p0.code_index == 4'h7))
        else $error("packet pair does not start with a sysex end");
    a_last_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n == 2'd2) |-> (!o_push.p0.last_of_run && o_push.p1.last_of_run))
        else $error("last_of_run misplaced in a packet pair");
    a_count_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_cnt != 2'd3))
        else $error("a full message was left unflushed");
`endif

endmodule

>>> src/mtup_queue.sv
// Packet queue between the parser and the output stage; takes up to two packets a cycle.
module mtup_queue #(
    parameter int DEPTH = mtup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtup_pkg::t_push   i_push,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_nonempty,
    output mtup_pkg::t_pkt    o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mtup_pkg::t_pkt  r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wr1;
    logic [PW-1:0]   wr2;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr1 = ptr_inc(r_wr);
    assign wr2 = ptr_inc(wr1);

    // Room for a full pair is required, whatever the byte turns out to produce.
    assign o_ready    = (r_count <= CW'(DEPTH - 2));
    assign o_nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.p0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr1] <= i_push.p1;
        end
    end

    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.n == 2'd1) begin
                r_wr <= wr1;
            end else if (i_push.n == 2'd2) begin
                r_wr <= wr2;
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_count <= r_count + CW'(i_push.n) - CW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CW + 1)'(r_count) + (CW + 1)'(i_push.n) <= (CW + 1)'(DEPTH)))
        else $error("packet queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty packet queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("packet queue count beyond depth");
`endif

endmodule

>>> src/mtup_back.sv
// Output stage: registers the head packet of the queue and presents it to the stream.
module mtup_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  mtup_pkg::t_pkt    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output mtup_pkg::t_pkt    o_pkt
);

    logic           r_valid;
    mtup_pkg::t_pkt r_pkt;
    logic           take;

    // The register takes a new packet when empty or when its packet leaves now.
    assign take  = !r_valid || i_ready;
    assign o_pop = take && i_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_pkt   = r_pkt;

endmodule

>>> src/midi_to_usb_midi_packetizer.sv
// Top level of the serial MIDI to USB-MIDI event packetizer.
//
// MIDI bytes enter on the s_axis channel, one byte in s_axis_tdata[7:0]. Each
// accepted byte yields zero, one or two USB-MIDI event packets on m_axis:
// tdata[3:0] code index, [7:4] cable, then the three MIDI bytes, and tlast set
// on the last packet caused by the byte. Two registers sit on the APB port:
// raw_mode at 0x0 and cable_number at 0x4; write them only while idle.
//
// A byte is taken every cycle while the packet queue has room for two packets.
// A packet that an accepted byte completes is written into the queue, then moved
// into the output register and offered on m_axis. Sustained rate is one byte per
// cycle while the receiver takes every packet; the output register moves one packet
// per cycle, so a byte that closes a sysex and completes a new message gives it two.
// When the receiver stalls, packets collect in the queue (QUEUE_DEPTH entries)
// and s_axis_tready falls once fewer than two slots remain. Synchronous reset
// clears the parser state and both registers and empties the queue and output register.
module midi_to_usb_midi_packetizer #(
    parameter int QUEUE_DEPTH = mtup_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // midi_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // code_index, cable, first_byte, second_byte, third_byte
    output logic        m_axis_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_raw_mode;
    logic [3:0]      r_cable;
    logic            cfg_write;
    logic            accept;
    mtup_pkg::t_cfg  cfg;
    mtup_pkg::t_push push;
    logic            pop;
    logic            nonempty;
    mtup_pkg::t_pkt  head;
    mtup_pkg::t_pkt  out_pkt;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode <= 1'b0;
            r_cable    <= 4'h0;
        end else if (cfg_write) begin
            case (paddr[2])
                mtup_pkg::REG_RAW_MODE: r_raw_mode <= pwdata[0];
                mtup_pkg::REG_CABLE:    r_cable    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mtup_pkg::REG_RAW_MODE: prdata = {31'b0, r_raw_mode};
            mtup_pkg::REG_CABLE:    prdata = {28'b0, r_cable};
            default:                prdata = '0;
        endcase
    end

    assign cfg.raw_mode     = r_raw_mode;
    assign cfg.cable_number = r_cable;
    assign accept           = s_axis_tvalid && s_axis_tready;

    mtup_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    mtup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_ready    (s_axis_tready),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    mtup_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pkt      (out_pkt)
    );

    assign m_axis_tdata = {out_pkt.third_byte, out_pkt.second_byte, out_pkt.first_byte,
                           out_pkt.cable, out_pkt.code_index};
    assign m_axis_tlast = out_pkt.last_of_run;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the MIDI to USB-MIDI event packetizer.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [7:0] CHAN_FIRST     = 8'h80;
    localparam logic [7:0] NOTE_ON        = 8'h90;
    localparam logic [7:0] PROG_CHANGE    = 8'hC0;
    localparam logic [7:0] MTC_QUARTER    = 8'hF1;
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] SONG_SELECT    = 8'hF3;
    localparam logic [7:0] UNDEF_COMMON_A = 8'hF4;
    localparam logic [7:0] UNDEF_COMMON_B = 8'hF5;
    localparam logic [7:0] TUNE_REQUEST   = 8'hF6;
    localparam logic [7:0] TIMING_CLOCK   = 8'hF8;
    localparam logic [7:0] UNDEF_RT_A     = 8'hF9;
    localparam logic [7:0] UNDEF_RT_B     = 8'hFD;
    localparam logic [7:0] SYSTEM_RESET   = 8'hFF;

    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 5000;
    localparam int MAX_PRINTED    = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // midi_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // code_index, cable, first_byte, second_byte, third_byte
    logic        m_axis_tlast;   // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    midi_to_usb_midi_packetizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow of the block's configuration and parser state.
    logic       wrap_raw;
    logic [3:0] cable_sel;
    logic [7:0] run_status;
    logic [1:0] run_count;
    logic [7:0] run_bytes [3];

    mtup_pkg::t_pkt owed_packets [$];
    mtup_pkg::t_pkt byte_packets [$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    int mismatches;
    int bytes_in;
    int bytes_used;
    int packets_checked;
    int double_bytes;
    logic [15:0] codes_seen;
    int quiet_cycles;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    function automatic logic [1:0] msg_length(input logic [7:0] s);
        if (!s[7]) begin
            return 2'd0;
        end
        if (s < mtup_pkg::STATUS_SYSEX) begin
            return mtup_pkg::CHAN_LEN[s[6:4]];
        end
        return mtup_pkg::SYS_LEN[s[3:0]];
    endfunction

    task automatic add_packet(input logic [3:0] code, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c);
        mtup_pkg::t_pkt p;
        p.code_index  = code;
        p.cable       = cable_sel;
        p.first_byte  = a;
        p.second_byte = b;
        p.third_byte  = c;
        p.last_of_run = 1'b0;
        byte_packets.push_back(p);
    endtask

    // Emits the buffered message; channel messages keep their status for running status.
    task automatic close_message();
        logic [1:0] idx;
        logic [3:0] code;
        if (msg_length(run_status) == 2'd0) begin
            return;
        end
        idx = (run_count == 2'd0) ? 2'd0 : run_count - 2'd1;
        if (run_status < mtup_pkg::STATUS_SYSEX) begin
            code = run_status[7:4];
        end else if (run_status == mtup_pkg::STATUS_SYSEX) begin
            code = mtup_pkg::CIN_SYSEX_CONT;
            if (run_count != 2'd0 && run_bytes[idx] == mtup_pkg::SYSEX_END) begin
                code = mtup_pkg::CIN_SYSEX_CONT + {2'b00, run_count};
            end
        end else if (run_status < mtup_pkg::REALTIME_FIRST) begin
            code = mtup_pkg::COMMON_CODE[idx];
        end else begin
            code = mtup_pkg::CIN_SINGLE_BYTE;
        end
        add_packet(code, run_bytes[0], run_bytes[1], run_bytes[2]);
        run_bytes = '{8'h00, 8'h00, 8'h00};
        run_count = 2'd0;
        if (run_status < mtup_pkg::STATUS_SYSEX) begin
            run_bytes[0] = run_status;
            run_count    = 2'd1;
        end
        if (run_status > mtup_pkg::STATUS_SYSEX) begin
            run_status = 8'h00;
        end
    endtask

    // Works out the packets owed for one accepted MIDI byte and queues them.
    task automatic parse_midi_byte(input logic [7:0] b);
        logic [31:0] state_before;
        mtup_pkg::t_pkt p;
        state_before = {run_status, run_bytes[0], run_bytes[1], run_bytes[2]} ^ {30'b0, run_count};
        byte_packets.delete();
        if (wrap_raw) begin
            add_packet(mtup_pkg::CIN_SINGLE_BYTE, b, 8'h00, 8'h00);
        end else if (b >= mtup_pkg::REALTIME_FIRST) begin
            if (mtup_pkg::SYS_LEN[b[3:0]] != 2'd0) begin
                add_packet(mtup_pkg::CIN_SINGLE_BYTE, b, 8'h00, 8'h00);
            end
        end else begin
            if (b[7] && run_status == mtup_pkg::STATUS_SYSEX) begin
                if (run_count < 2'd3) begin
                    run_bytes[run_count] = mtup_pkg::SYSEX_END;
                    run_count++;
                end
                close_message();
            end
            if (b[7]) begin
                run_status = b;
                run_count  = 2'd0;
                run_bytes  = '{8'h00, 8'h00, 8'h00};
            end
            if (run_status != 8'h00 && msg_length(run_status) != 2'd0) begin
                if (run_count < 2'd3) begin
                    run_bytes[run_count] = b;
                    run_count++;
                end
                if (run_count >= msg_length(run_status)) begin
                    close_message();
                end
            end
        end
        foreach (byte_packets[i]) begin
            p = byte_packets[i];
            p.last_of_run = (i == byte_packets.size() - 1);
            owed_packets.push_back(p);
        end
        bytes_in++;
        if (byte_packets.size() > 1) begin
            double_bytes++;
        end
        if (byte_packets.size() > 0 || state_before !=
            ({run_status, run_bytes[0], run_bytes[1], run_bytes[2]} ^ {30'b0, run_count})) begin
            bytes_used++;
        end
    endtask

    // Observes all three ports at each edge; requests are predicted before packets are checked.
    always @(posedge i_clk) begin
        mtup_pkg::t_pkt want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mtup_pkg::REG_CABLE) begin
                    cable_sel = pwdata[3:0];
                end else begin
                    wrap_raw = pwdata[0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_midi_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_packets.size() == 0) begin
                    report("packet with none owed, tdata", m_axis_tdata, 32'h0);
                end else begin
                    want = owed_packets.pop_front();
                    packets_checked++;
                    codes_seen[m_axis_tdata[3:0]] = 1'b1;
                    if (m_axis_tdata[3:0] != want.code_index)
                        report("code_index", m_axis_tdata[3:0], want.code_index);
                    if (m_axis_tdata[7:4] != want.cable)
                        report("cable", m_axis_tdata[7:4], want.cable);
                    if (m_axis_tdata[15:8] != want.first_byte)
                        report("first_byte", m_axis_tdata[15:8], want.first_byte);
                    if (m_axis_tdata[23:16] != want.second_byte)
                        report("second_byte", m_axis_tdata[23:16], want.second_byte);
                    if (m_axis_tdata[31:24] != want.third_byte)
                        report("third_byte", m_axis_tdata[31:24], want.third_byte);
                    if (m_axis_tlast != want.last_of_run)
                        report("last_of_run", m_axis_tlast, want.last_of_run);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d packets still owed",
                     QUIET_LIMIT, owed_packets.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver side; a hold request stalls it for a long counted stretch.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stops offering requests and waits until every owed packet has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed_packets.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // A data byte, now and then preceded by a realtime byte slipped into the message.
    task automatic send_data();
        if ($urandom_range(19) == 0) begin
            send_byte(8'($urandom_range(mtup_pkg::REALTIME_FIRST, 8'hFF)));
        end
        send_byte(8'($urandom_range(0, 8'h7F)));
    endtask

    task automatic random_message();
        logic [7:0] st;
        int pick;
        int data_len;
        pick = $urandom_range(99);
        if (pick < 40) begin
            st = CHAN_FIRST + 8'({$urandom_range(6), 4'h0}) + 8'($urandom_range(15));
            send_byte(st);
            data_len = (st[6:4] == 3'd4 || st[6:4] == 3'd5) ? 1 : 2;
            repeat ($urandom_range(1, 4)) begin
                // Now and then a message is cut short.
                repeat (($urandom_range(9) == 0) ? $urandom_range(data_len) : data_len) send_data();
            end
        end else if (pick < 55) begin
            send_byte(mtup_pkg::STATUS_SYSEX);
            repeat ($urandom_range(10)) send_data();
            if ($urandom_range(3) != 0) begin
                send_byte(mtup_pkg::SYSEX_END);
            end else begin
                send_byte(8'($urandom_range(CHAN_FIRST, TUNE_REQUEST)));
            end
        end else if (pick < 67) begin
            case ($urandom_range(3))
                0: begin send_byte(MTC_QUARTER); send_data(); end
                1: begin send_byte(SONG_POSITION); send_data(); send_data(); end
                2: begin send_byte(SONG_SELECT); send_data(); end
                default: send_byte(TUNE_REQUEST);
            endcase
        end else if (pick < 75) begin
            send_byte(8'($urandom_range(mtup_pkg::REALTIME_FIRST, 8'hFF)));
        end else if (pick < 80) begin
            case ($urandom_range(2))
                0: send_byte(UNDEF_COMMON_A);
                1: send_byte(UNDEF_COMMON_B);
                default: send_byte(mtup_pkg::SYSEX_END);
            endcase
            repeat ($urandom_range(2)) send_data();
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(149) == 0) begin
            wait_drained();
        end
    endtask

    task automatic test_directed_messages();
        logic [7:0] seq [$];
        seq = '{8'h00, SYSTEM_RESET,
                NOTE_ON, 8'h3C, 8'h7F, 8'h45, 8'h00,
                mtup_pkg::STATUS_SYSEX, 8'h7E, TIMING_CLOCK, 8'h7F, 8'h06,
                mtup_pkg::SYSEX_END, 8'h11,
                UNDEF_COMMON_A, 8'h22, UNDEF_RT_A, UNDEF_RT_B,
                mtup_pkg::STATUS_SYSEX, 8'h01, TUNE_REQUEST,
                MTC_QUARTER, 8'h7F, 8'h55,
                PROG_CHANGE | 8'h0F, 8'h12};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();
    endtask

    task automatic test_raw_wrap();
        wait_drained();
        cfg_write(mtup_pkg::REG_RAW_MODE, 32'd1);
        cfg_write(mtup_pkg::REG_CABLE, 32'd15);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mtup_pkg::STATUS_SYSEX);
        send_byte(UNDEF_RT_A);
        repeat (150) send_byte(8'($urandom_range(255)));
        wait_drained();
        cfg_write(mtup_pkg::REG_RAW_MODE, 32'd0);
    endtask

    task automatic test_random_stream(input logic [3:0] cable, input int count);
        int start;
        wait_drained();
        cfg_write(mtup_pkg::REG_CABLE, {28'b0, cable});
        start = bytes_used;
        while (bytes_used - start < count) random_message();
        wait_drained();
    endtask

    // The receiver stalls while requests keep coming, so the packet queue fills up.
    task automatic test_backpressure();
        wait_drained();
        cfg_write(mtup_pkg::REG_CABLE, 32'd10);
        hold_req = 1'b1;
        repeat (30) begin
            send_byte(NOTE_ON | 8'($urandom_range(15)));
            send_data();
            send_data();
            send_byte(mtup_pkg::STATUS_SYSEX);
            send_data();
            send_byte(TUNE_REQUEST);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        wrap_raw      = 1'b0;
        cable_sel     = 4'd0;
        run_status    = 8'h00;
        run_count     = 2'd0;
        run_bytes     = '{8'h00, 8'h00, 8'h00};
        hold_req      = 1'b0;
        mismatches    = 0;
        bytes_in      = 0;
        bytes_used    = 0;
        packets_checked = 0;
        double_bytes  = 0;
        codes_seen    = 16'h0;
        quiet_cycles  = 0;
        tx_idle_pct   = 30;
        rx_idle_pct   = 67;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(mtup_pkg::REG_RAW_MODE, 32'd0);
        cfg_write(mtup_pkg::REG_CABLE, 32'd0);

        test_directed_messages();
        test_raw_wrap();
        test_random_stream(4'd15, 400);

        tx_idle_pct = 67;
        rx_idle_pct = 30;
        test_random_stream(4'd5, 400);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random_stream(4'd0, 400);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (owed_packets.size() != 0) begin
            report("packets still owed at end", owed_packets.size(), 32'd0);
        end
        $display("Summary: %0d MIDI bytes taken, %0d of them effective, %0d packets checked",
                 bytes_in, bytes_used, packets_checked);
        $display("Summary: %0d bytes gave two packets, code indexes seen mask %04h, %0d mismatches",
                 double_bytes, codes_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mtup_pkg.sv
src/mtup_front.sv
src/mtup_queue.sv
src/mtup_back.sv
src/midi_to_usb_midi_packetizer.sv
dv/tb_top.sv
